@@ design/ussw_pkg.sv @@
`default_nettype none
package ussw_pkg;

    localparam int POS_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] REQ_START = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_TIME    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_DELAY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_MAX    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_DEG     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MAX    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_MIN    = 3'd6;

    localparam logic [15:0]       RST_MOVE_TIME   = 16'd500;
    localparam logic [7:0]        RST_RETRY_DELAY = 8'd10;
    localparam logic [3:0]        RST_RETRY_MAX   = 4'd3;
    localparam logic [5:0]        RST_STEP_DEG    = 6'd10;
    localparam logic signed [5:0] RST_CENTER_OFS  = 6'sd0;
    localparam logic [6:0]        RST_ANGLE_MAX   = 7'd90;
    localparam logic signed [7:0] RST_ANGLE_MIN   = -8'sd90;

    localparam int          SERVO_CENTER = 90;
    localparam logic [15:0] MIN_DIST_MM  = 16'd10;

    typedef struct packed {
        logic        acted;
        logic        servo_valid;
        logic [7:0]  servo_cmd;
        logic        running;
        logic        done;
        logic [3:0]  retries_used;
        logic [15:0] late_ms;
        logic        rd_hit;
    } result_t;

endpackage
`default_nettype wire

@@ design/ussw_table.sv @@
`default_nettype none
module ussw_table
    import ussw_pkg::*;
#(
    parameter int STEPS = 16,
    parameter int AW    = 4
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [15:0]   wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic [15:0]        rd_data
);

    logic [15:0]      table_mem [STEPS];
    logic [STEPS-1:0] valid_reg;
    logic [15:0]      rd_data_reg;
    logic             rd_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
        end
    end

    // An entry never written since reset reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_ok_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_ok_reg ? rd_data_reg : 16'd0;

endmodule
`default_nettype wire

@@ design/ussw_ctrl.sv @@
`default_nettype none
module ussw_ctrl
    import ussw_pkg::*;
#(
    parameter int STEPS = 16,
    parameter int AW    = 4
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  acc,
    input  wire logic [1:0]            req_type,
    input  wire logic [31:0]           now_ms,
    input  wire logic [15:0]           distance_mm,
    input  wire logic [7:0]            read_index,
    output result_t                    res,
    output logic                       tbl_we,
    output logic [AW-1:0]              tbl_waddr,
    output logic [15:0]                tbl_wdata
);

    logic [15:0]       move_time_reg;
    logic [7:0]        retry_delay_reg;
    logic [3:0]        retry_max_reg;
    logic [5:0]        step_deg_reg;
    logic signed [5:0] center_ofs_reg;
    logic [6:0]        angle_max_reg;
    logic signed [7:0] angle_min_reg;

    logic                    running_reg, running_next;
    logic                    done_reg, done_next;
    logic                    reverse_reg, reverse_next;
    logic                    first_reg, first_next;
    logic signed [POS_W-1:0] position_reg, position_next;
    logic [31:0]             deadline_reg, deadline_next;
    logic [3:0]              retry_reg, retry_next;
    logic [15:0]             late_reg, late_next;

    logic signed [POS_W-1:0] pos_step;
    logic [31:0]             late_diff;
    logic                    reported;
    logic                    store;

    function automatic logic [7:0] servo_for(
        input logic signed [7:0] idx,
        input logic [5:0]        stp,
        input logic signed [5:0] ofs,
        input logic [6:0]        amax,
        input logic signed [7:0] amin
    );
        logic signed [14:0] rel_w;
        logic signed [14:0] stp_w;
        logic signed [14:0] ang;
        logic signed [14:0] cmd;
        rel_w = 15'(idx) - 15'(STEPS / 2);
        stp_w = $signed({9'd0, stp});
        ang   = rel_w * stp_w;
        // The upper clamp goes first, so the lower one wins when they cross.
        if (ang > $signed({8'd0, amax}))
        begin
            ang = $signed({8'd0, amax});
        end
        if (ang < 15'(amin))
        begin
            ang = 15'(amin);
        end
        cmd = 15'(SERVO_CENTER) + 15'(ofs) - ang;
        return cmd[7:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            move_time_reg   <= RST_MOVE_TIME;
            retry_delay_reg <= RST_RETRY_DELAY;
            retry_max_reg   <= RST_RETRY_MAX;
            step_deg_reg    <= RST_STEP_DEG;
            center_ofs_reg  <= RST_CENTER_OFS;
            angle_max_reg   <= RST_ANGLE_MAX;
            angle_min_reg   <= RST_ANGLE_MIN;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MOVE_TIME:   move_time_reg   <= cfg_data[15:0];
                CFG_RETRY_DELAY: retry_delay_reg <= cfg_data[7:0];
                CFG_RETRY_MAX:   retry_max_reg   <= cfg_data[3:0];
                CFG_STEP_DEG:    step_deg_reg    <= cfg_data[5:0];
                CFG_CENTER_OFS:  center_ofs_reg  <= $signed(cfg_data[5:0]);
                CFG_ANGLE_MAX:   angle_max_reg   <= cfg_data[6:0];
                CFG_ANGLE_MIN:   angle_min_reg   <= $signed(cfg_data[7:0]);
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        running_next  = running_reg;
        done_next     = done_reg;
        reverse_next  = reverse_reg;
        first_next    = first_reg;
        position_next = position_reg;
        deadline_next = deadline_reg;
        retry_next    = retry_reg;
        late_next     = late_reg;
        reported      = 1'b0;
        store         = 1'b0;
        res           = '0;
        pos_step      = reverse_reg ? position_reg - POS_W'(1) : position_reg + POS_W'(1);
        late_diff     = now_ms - deadline_reg;
        tbl_wdata     = (retry_reg >= retry_max_reg) ? 16'd0 : distance_mm;
        tbl_waddr     = position_reg[AW-1:0];

        case (req_type)
            REQ_START:
            begin
                running_next = 1'b1;
                done_next    = 1'b0;
                retry_next   = 4'd0;
                first_next   = 1'b1;
                res.acted    = 1'b1;
                if (!reverse_reg && position_reg >= POS_W'(STEPS - 1))
                begin
                    position_next = POS_W'(STEPS - 1);
                    reverse_next  = 1'b1;
                end
                else
                begin
                    position_next = '0;
                    reverse_next  = 1'b0;
                end
            end
            REQ_READ:
            begin
                res.acted  = 1'b1;
                res.rd_hit = (read_index < 8'(STEPS));
            end
            REQ_TICK:
            begin
                if (running_reg)
                begin
                    if (first_reg)
                    begin
                        res.servo_valid = 1'b1;
                        res.servo_cmd   = servo_for(position_reg, step_deg_reg,
                                              center_ofs_reg, angle_max_reg, angle_min_reg);
                        deadline_next   = now_ms + 32'(move_time_reg);
                        first_next      = 1'b0;
                        res.acted       = 1'b1;
                    end
                    else if (now_ms >= deadline_reg)
                    begin
                        late_next = (|late_diff[31:16]) ? 16'hFFFF : late_diff[15:0];
                        res.acted = 1'b1;
                        if (distance_mm < MIN_DIST_MM && retry_reg < retry_max_reg)
                        begin
                            deadline_next = now_ms + 32'(retry_delay_reg);
                            retry_next    = retry_reg + 4'd1;
                        end
                        else
                        begin
                            store         = 1'b1;
                            reported      = 1'b1;
                            retry_next    = 4'd0;
                            position_next = pos_step;
                            deadline_next = now_ms + 32'(move_time_reg);
                            if ((!reverse_reg && pos_step >= POS_W'(STEPS)) ||
                                (reverse_reg && pos_step < 0))
                            begin
                                running_next = 1'b0;
                                done_next    = 1'b1;
                            end
                            else
                            begin
                                res.servo_valid = 1'b1;
                                res.servo_cmd   = servo_for(pos_step, step_deg_reg,
                                                  center_ofs_reg, angle_max_reg,
                                                  angle_min_reg);
                            end
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        res.running      = running_next;
        res.done         = done_next;
        res.retries_used = reported ? retry_reg : retry_next;
        res.late_ms      = late_next;
        tbl_we           = acc && store;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg  <= 1'b0;
            done_reg     <= 1'b0;
            reverse_reg  <= 1'b0;
            first_reg    <= 1'b0;
            position_reg <= '0;
            deadline_reg <= '0;
            retry_reg    <= '0;
            late_reg     <= '0;
        end
        else if (acc)
        begin
            running_reg  <= running_next;
            done_reg     <= done_next;
            reverse_reg  <= reverse_next;
            first_reg    <= first_next;
            position_reg <= position_next;
            deadline_reg <= deadline_next;
            retry_reg    <= retry_next;
            late_reg     <= late_next;
        end
    end

endmodule
`default_nettype wire

@@ design/ultrasonic_sweep_sequencer.sv @@
`default_nettype none
// Channel   Direction  Handshake            Words
// request   in         in_valid / in_stall  req_type, now_ms, distance_mm, read_index
// result    out        out_valid / out_stall acted .. late_ms, one per request word
// config    in         cfg_we               cfg_index, cfg_data
//
// One request word is taken every cycle unless stalled; its result goes through both stages.
// Stage one updates the sweep state and addresses the range table, whose read port
// is registered; stage two is the output register.
// A write to the table lands before the next word reads it, so no forwarding is needed.
// Reset clears the sweep state and the table's per-entry valid bits at once.
// A stalled output holds its word, and the request side stalls only when both stages are full.
module ultrasonic_sweep_sequencer
    import ussw_pkg::*;
#(
    parameter int STEPS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [1:0]            req_type,
    input  wire logic [31:0]           now_ms,
    input  wire logic [15:0]           distance_mm,
    input  wire logic [7:0]            read_index,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       acted,
    output logic                       servo_valid,
    output logic [7:0]                 servo_cmd,
    output logic                       sweep_running,
    output logic                       sweep_done,
    output logic [15:0]                stored_dist_mm,
    output logic [3:0]                 retries_used,
    output logic [15:0]                late_ms
);

    localparam int AW = (STEPS > 1) ? $clog2(STEPS) : 1;

    result_t       res;
    logic          tbl_we;
    logic [AW-1:0] tbl_waddr;
    logic [15:0]   tbl_wdata;
    logic [15:0]   rd_data;

    logic          in_acc;
    logic          s1_move;
    logic          s1_valid_reg;
    result_t       s1_res_reg;
    logic          out_valid_reg;
    result_t       out_res_reg;
    logic [15:0]   out_dist_reg;

    assign s1_move  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_move;
    assign in_acc   = in_valid && !in_stall;

    ussw_ctrl #(
        .STEPS (STEPS),
        .AW    (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .acc         (in_acc),
        .req_type    (req_type),
        .now_ms      (now_ms),
        .distance_mm (distance_mm),
        .read_index  (read_index),
        .res         (res),
        .tbl_we      (tbl_we),
        .tbl_waddr   (tbl_waddr),
        .tbl_wdata   (tbl_wdata)
    );

    // The read data register only moves on an accepted word, so it holds with stage one.
    ussw_table #(
        .STEPS (STEPS),
        .AW    (AW)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (tbl_we),
        .wr_addr (tbl_waddr),
        .wr_data (tbl_wdata),
        .rd_en   (in_acc),
        .rd_addr (read_index[AW-1:0]),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_res_reg <= res;
        end
        if (s1_move)
        begin
            out_res_reg  <= s1_res_reg;
            out_dist_reg <= s1_res_reg.rd_hit ? rd_data : 16'd0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign acted          = out_res_reg.acted;
    assign servo_valid    = out_res_reg.servo_valid;
    assign servo_cmd      = out_res_reg.servo_cmd;
    assign sweep_running  = out_res_reg.running;
    assign sweep_done     = out_res_reg.done;
    assign stored_dist_mm = out_dist_reg;
    assign retries_used   = out_res_reg.retries_used;
    assign late_ms        = out_res_reg.late_ms;

endmodule
`default_nettype wire
